FILE: hw/rtl/assert_macros.svh
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define AST_IMPL(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, disabled while reset is low
`define AST_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

FILE: hw/rtl/dmfr_pkg.sv
package dmfr_pkg;

    localparam int BUFFER_BYTES_DEF = 256;

    localparam logic [7:0] MARK_BINARY  = 8'hA0;
    localparam logic [7:0] CHAR_CR      = 8'h0D;
    localparam logic [7:0] CHAR_LF      = 8'h0A;
    localparam int         BINARY_EXTRA = 7;
    localparam int         LEN_W        = 9;

    localparam int IN_DATA_W  = 16;
    localparam int IN_USER_W  = 2;
    localparam int OUT_DATA_W = 24;

    typedef enum logic [1:0] {
        MODE_BYTE    = 2'd0,
        MODE_READ    = 2'd1,
        MODE_RELEASE = 2'd2,
        MODE_NONE    = 2'd3
    } t_mode;

    typedef struct packed {
        logic             binary_frame;
        logic             cr_seen;
        logic [LEN_W-1:0] frame_length;
        logic             frame_ready;
    } t_status;

endpackage

FILE: hw/rtl/dmfr_ram.sv
module dmfr_ram
    #(
        parameter int WIDTH = 8,
        parameter int DEPTH = 256
    )
    (
        input  logic                     i_clk,
        input  logic                     i_we,
        input  logic [$clog2(DEPTH)-1:0] i_waddr,
        input  logic [WIDTH-1:0]         i_wdata,
        input  logic                     i_re,
        input  logic [$clog2(DEPTH)-1:0] i_raddr,
        output logic [WIDTH-1:0]         o_rdata
    );

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hw/rtl/dmfr_ctrl.sv
module dmfr_ctrl
    import dmfr_pkg::*;
    #(
        parameter int BUFFER_BYTES = BUFFER_BYTES_DEF
    )
    (
        input  logic                            i_clk,
        input  logic                            i_rst_n,
        input  logic                            i_valid,
        input  t_mode                           i_mode,
        input  logic [7:0]                      i_rx_byte,
        input  logic [7:0]                      i_read_index,
        output logic                            o_we,
        output logic [$clog2(BUFFER_BYTES)-1:0] o_waddr,
        output logic [7:0]                      o_wdata,
        output logic                            o_re,
        output logic                            o_read_hit,
        output logic [$clog2(BUFFER_BYTES)-1:0] o_raddr,
        output t_status                         o_status
    );

    localparam int CW   = $clog2(BUFFER_BYTES);
    localparam int WANT_W = 17;

    logic [CW-1:0] r_count, n_count;
    logic          r_cr, n_cr;
    logic          r_done, n_done;
    logic [7:0]    r_first, n_first;
    logic [7:0]    r_len_hi, n_len_hi;
    logic [7:0]    r_len_lo, n_len_lo;

    logic [CW:0]       cnt_inc;
    logic              ovf;
    logic              is_bin;
    logic [WANT_W-1:0] want;
    logic [CW+7:0]     idx_ext;
    logic [CW+LEN_W-1:0] len_ext;

    assign cnt_inc = {1'b0, r_count} + (CW+1)'(1);
    assign ovf     = (cnt_inc == (CW+1)'(BUFFER_BYTES));
    assign is_bin  = (r_count == '0) ? (i_rx_byte == MARK_BINARY) : (r_first == MARK_BINARY);

    always_comb begin
        n_count  = r_count;
        n_cr     = r_cr;
        n_done   = r_done;
        n_first  = r_first;
        n_len_hi = r_len_hi;
        n_len_lo = r_len_lo;
        o_we     = 1'b0;
        o_waddr  = r_count;
        o_wdata  = i_rx_byte;
        want     = '0;
        if (i_valid) begin
            unique case (i_mode)
                MODE_BYTE: begin
                    if (r_done) begin
                        o_we    = 1'b1;
                        o_waddr = '0;
                        n_first = i_rx_byte;
                        n_count = CW'(1);
                        n_cr    = 1'b0;
                        n_done  = 1'b0;
                    end else if (r_cr && !is_bin) begin
                        if (i_rx_byte != CHAR_LF) begin
                            n_count = '0;
                            n_cr    = 1'b0;
                            n_done  = 1'b0;
                        end else begin
                            o_we   = 1'b1;
                            n_done = 1'b1;
                        end
                    end else begin
                        o_we = 1'b1;
                        if (r_count == '0) begin
                            n_first = i_rx_byte;
                        end
                        if (r_count == CW'(2)) begin
                            n_len_hi = i_rx_byte;
                        end
                        if (r_count == CW'(3)) begin
                            n_len_lo = i_rx_byte;
                        end
                        if (!is_bin && i_rx_byte == CHAR_CR) begin
                            n_cr = 1'b1;
                        end
                        want = {1'b0, n_len_hi, n_len_lo} + WANT_W'(BINARY_EXTRA);
                        if (ovf) begin
                            n_count = '0;
                            n_cr    = 1'b0;
                            n_done  = 1'b0;
                        end else begin
                            n_count = cnt_inc[CW-1:0];
                            if (is_bin && cnt_inc >= (CW+1)'(4)
                                && WANT_W'(cnt_inc) == want) begin
                                n_done = 1'b1;
                            end
                        end
                    end
                end
                MODE_RELEASE: begin
                    n_count = '0;
                    n_cr    = 1'b0;
                    n_done  = 1'b0;
                end
                MODE_READ, MODE_NONE: begin
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_cr     <= 1'b0;
            r_done   <= 1'b0;
            r_first  <= '0;
            r_len_hi <= '0;
            r_len_lo <= '0;
        end else begin
            r_count  <= n_count;
            r_cr     <= n_cr;
            r_done   <= n_done;
            r_first  <= n_first;
            r_len_hi <= n_len_hi;
            r_len_lo <= n_len_lo;
        end
    end

    assign idx_ext    = (CW+8)'(i_read_index);
    assign o_raddr    = idx_ext[CW-1:0];
    assign o_read_hit = (32'(i_read_index) < BUFFER_BYTES);
    assign o_re       = i_valid && (i_mode == MODE_READ) && o_read_hit;

    assign len_ext               = (CW+LEN_W)'(n_count);
    assign o_status.frame_ready  = n_done;
    assign o_status.frame_length = len_ext[LEN_W-1:0];
    assign o_status.cr_seen      = n_cr;
    assign o_status.binary_frame = (n_count != '0) && (n_first == MARK_BINARY);

endmodule

FILE: hw/rtl/dual_mode_frame_receiver.sv
// channel | dir | tdata (low bit up)                              | tuser
// s_axis  | in  | rx_byte[7:0], read_index[15:8]                  | mode[1:0]
// m_axis  | out | read_data[7:0], frame_ready[8], frame_length[17:9],
//         |     | cr_seen[18], binary_frame[19], zero pad [23:20] | -
// one beat accepted per cycle unless a stalled output blocks it; frame state updates
// and the buffer ram read happen at acceptance, and each result then passes through
// the ram read register and the output register
// i_rst_n synchronous active low clears frame state and both pipeline valids
// buffer contents are not cleared by reset
// a stalled output holds its beat; input is taken while the pipeline can drain
module dual_mode_frame_receiver
    import dmfr_pkg::*;
    #(
        parameter int BUFFER_BYTES = BUFFER_BYTES_DEF
    )
    (
        input  logic                  i_clk,
        input  logic                  i_rst_n,
        input  logic                  i_s_tvalid,
        output logic                  o_s_tready,
        input  logic [IN_DATA_W-1:0]  i_s_tdata,  // rx_byte, read_index
        input  logic [IN_USER_W-1:0]  i_s_tuser,  // mode
        output logic                  o_m_tvalid,
        input  logic                  i_m_tready,
        output logic [OUT_DATA_W-1:0] o_m_tdata   // read_data, frame_ready, frame_length,
                                                  // cr_seen, binary_frame
    );

    localparam int AW = $clog2(BUFFER_BYTES);

    logic          accept;
    logic          out_free;
    logic          s1_move;
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [7:0]    ram_wdata;
    logic          ram_re;
    logic [AW-1:0] ram_raddr;
    logic [7:0]    ram_rdata;
    logic          read_hit;
    t_status       status;

    logic                  r_s1_valid;
    t_status               r_s1_status;
    logic                  r_s1_hit;
    logic                  r_out_valid;
    logic [OUT_DATA_W-1:0] r_out_data;

    assign out_free   = !r_out_valid || i_m_tready;
    assign s1_move    = r_s1_valid && out_free;
    assign o_s_tready = !r_s1_valid || out_free;
    assign accept     = i_s_tvalid && o_s_tready;

    dmfr_ctrl #(
        .BUFFER_BYTES(BUFFER_BYTES)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (accept),
        .i_mode      (t_mode'(i_s_tuser)),
        .i_rx_byte   (i_s_tdata[7:0]),
        .i_read_index(i_s_tdata[15:8]),
        .o_we        (ram_we),
        .o_waddr     (ram_waddr),
        .o_wdata     (ram_wdata),
        .o_re        (ram_re),
        .o_read_hit  (read_hit),
        .o_raddr     (ram_raddr),
        .o_status    (status)
    );

    dmfr_ram #(
        .WIDTH(8),
        .DEPTH(BUFFER_BYTES)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_re   (ram_re),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_s1_valid <= 1'b1;
            end else if (s1_move) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_move) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
        if (accept) begin
            r_s1_status <= status;
            r_s1_hit    <= ram_re && read_hit;
        end
        if (s1_move) begin
            r_out_data <= {4'b0, r_s1_status, (r_s1_hit ? ram_rdata : 8'h00)};
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

endmodule

FILE: hw/rtl/dmfr_checker.sv
`include "assert_macros.svh"

module dmfr_checker
    import dmfr_pkg::*;
    (
        input logic                  i_clk,
        input logic                  i_rst_n,
        input logic                  o_s_tready,
        input logic                  o_m_tvalid,
        input logic                  i_m_tready,
        input logic [OUT_DATA_W-1:0] o_m_tdata
    );

    `AST_NEXT(a_out_hold, i_clk, i_rst_n, o_m_tvalid && !i_m_tready, o_m_tvalid && $stable(o_m_tdata))
    `AST_IMPL(a_no_idle_stall, i_clk, i_rst_n, !o_s_tready, o_m_tvalid && !i_m_tready)
    `AST_NEXT(a_reset_empty, i_clk, 1'b1, !i_rst_n, !o_m_tvalid && o_s_tready)
    `AST_IMPL(a_binary_len, i_clk, i_rst_n, o_m_tvalid && o_m_tdata[19], o_m_tdata[17:9] != 9'd0)

endmodule

bind dual_mode_frame_receiver dmfr_checker u_chk (
    .i_clk     (i_clk),
    .i_rst_n   (i_rst_n),
    .o_s_tready(o_s_tready),
    .o_m_tvalid(o_m_tvalid),
    .i_m_tready(i_m_tready),
    .o_m_tdata (o_m_tdata)
);
